/* hw/rtl/lbb_pkg.sv */
// Shared types, widths and constants of the LED blink and breathe controller.
package lbb_pkg;

    localparam int LED_CHANNELS_DEF = 3;
    localparam int DUTY_W           = 16;
    localparam int PULSE_W          = 8;
    localparam int LEN_W            = 16;
    localparam int HALF_W           = 15;
    localparam int BREATHE_CNT_W    = 8;
    localparam int OUT_LEDS         = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    localparam int ERROR_LED     = 0;
    localparam int HEARTBEAT_LED = 1;
    localparam int INDICATOR_LED = 2;

    localparam logic [DUTY_W-1:0]        FULL_DUTY          = 16'hFFFF;
    localparam logic [DUTY_W-1:0]        BREATHE_STEP_RST   = 16'd1000;
    localparam logic [BREATHE_CNT_W-1:0] BREATHE_PERIOD_RST = 8'd20;
    localparam logic [DUTY_W-1:0]        BREATHE_MAX_RST    = 16'hFFFF;
    localparam logic [DUTY_W-1:0]        BREATHE_MIN_RST    = 16'd0;
    localparam logic [DUTY_W-1:0]        FAULT_DUTY_RST     = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BREATHE_STEP      = 3'd0,
        CFG_BREATHE_PERIOD_MS = 3'd1,
        CFG_BREATHE_MAX_DUTY  = 3'd2,
        CFG_BREATHE_MIN_DUTY  = 3'd3,
        CFG_FAULT_DUTY        = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_BLINK = 1'b1
    } func_t;

    // Per-channel flashing state, including the duty held for the LED.
    typedef struct packed {
        logic                flash_on;
        logic [PULSE_W-1:0]  pulses_left;
        logic [HALF_W-1:0]   phase_len;
        logic [HALF_W-1:0]   phase_countdown;
        logic [DUTY_W-1:0]   duty;
    } flash_state_t;

    // Controls handed to one flashing channel for the current item.
    typedef struct packed {
        logic                tick;
        logic                load;
        logic [PULSE_W-1:0]  pulse_count;
        logic [HALF_W-1:0]   phase_len;
    } flash_ctrl_t;

endpackage

/* hw/rtl/lbb_in_if.sv */
// Input channel: tick and blink command items with a valid/ready handshake.
interface lbb_in_if
    import lbb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               func;
    logic [1:0]         led_select;
    logic [PULSE_W-1:0] pulse_count;
    logic [LEN_W-1:0]   pulse_length_ms;
    logic               error_flag;

    modport source (
        output valid, func, led_select, pulse_count, pulse_length_ms, error_flag,
        input  ready
    );
    modport sink (
        input  valid, func, led_select, pulse_count, pulse_length_ms, error_flag,
        output ready
    );
endinterface

/* hw/rtl/lbb_out_if.sv */
// Output channel: held LED duties and the rewritten mask, valid/ready handshake.
interface lbb_out_if
    import lbb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DUTY_W-1:0]   error_led_duty;
    logic [DUTY_W-1:0]   heartbeat_led_duty;
    logic [DUTY_W-1:0]   indicator_led_duty;
    logic [OUT_LEDS-1:0] written_mask;

    modport source (
        output valid, error_led_duty, heartbeat_led_duty, indicator_led_duty, written_mask,
        input  ready
    );
    modport sink (
        input  valid, error_led_duty, heartbeat_led_duty, indicator_led_duty, written_mask,
        output ready
    );
endinterface

/* hw/rtl/lbb_flash_channel.sv */
// Next-state logic of one blinking LED channel.
module lbb_flash_channel
    import lbb_pkg::*;
(
    input  flash_ctrl_t  ctrl,
    input  flash_state_t cur,
    output flash_state_t nxt,
    output logic         written
);

    logic [HALF_W-1:0] phase_dec;

    // The countdown saturates at zero, so a zero half period toggles every tick.
    assign phase_dec = (cur.phase_countdown != '0) ? cur.phase_countdown - 1'b1 : '0;

    always_comb
    begin
        nxt     = cur;
        written = 1'b0;
        if (ctrl.load)
        begin
            nxt.flash_on        = 1'b0;
            nxt.pulses_left     = ctrl.pulse_count;
            nxt.phase_len       = ctrl.phase_len;
            nxt.phase_countdown = ctrl.phase_len;
        end
        else if (ctrl.tick && (cur.pulses_left != '0))
        begin
            if (phase_dec != '0)
            begin
                nxt.phase_countdown = phase_dec;
            end
            else
            begin
                nxt.flash_on        = ~cur.flash_on;
                nxt.phase_countdown = cur.phase_len;
                written             = 1'b1;
                if (!cur.flash_on)
                begin
                    nxt.duty = FULL_DUTY;
                end
                else
                begin
                    nxt.duty        = '0;
                    nxt.pulses_left = cur.pulses_left - 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/lbb_breathe.sv */
// One step of the heartbeat triangle ramp, clamped at the configured limits.
module lbb_breathe
    import lbb_pkg::*;
(
    input  logic [DUTY_W-1:0] level,
    input  logic              rising,
    input  logic [DUTY_W-1:0] step,
    input  logic [DUTY_W-1:0] max_duty,
    input  logic [DUTY_W-1:0] min_duty,
    output logic [DUTY_W-1:0] level_next,
    output logic              rising_next
);

    localparam int EXT_W = DUTY_W + 2;

    logic signed [EXT_W-1:0] up_sum;
    logic signed [EXT_W-1:0] down_diff;
    logic signed [EXT_W-1:0] max_ext;
    logic signed [EXT_W-1:0] min_ext;

    // Two spare bits hold both the carry of a rising step and the sign of a falling one.
    assign up_sum    = $signed({2'b00, level}) + $signed({2'b00, step});
    assign down_diff = $signed({2'b00, level}) - $signed({2'b00, step});
    assign max_ext   = $signed({2'b00, max_duty});
    assign min_ext   = $signed({2'b00, min_duty});

    always_comb
    begin
        rising_next = rising;
        if (rising)
        begin
            if (up_sum >= max_ext)
            begin
                level_next  = max_duty;
                rising_next = 1'b0;
            end
            else
            begin
                level_next = up_sum[DUTY_W-1:0];
            end
        end
        else
        begin
            if (down_diff <= min_ext)
            begin
                level_next  = min_duty;
                rising_next = 1'b1;
            end
            else
            begin
                level_next = down_diff[DUTY_W-1:0];
            end
        end
    end

endmodule

/* hw/rtl/led_blink_breathe_controller.sv */
// Top level of the LED blink and breathe controller.
//
// Usage: items arrive on in_ch. An item with func = tick stands for one
// millisecond; it advances every blinking channel and the heartbeat ramp and
// may force the error LED to the fault duty. An item with func = blink loads a
// pulse count and half period into the channel named by led_select; a select
// beyond the last channel is ignored. Every item, of either kind, yields one
// transfer on out_ch with the duty held for the three LEDs and a mask of the
// LEDs that the item rewrote.
// The configuration port writes one register per cycle while cfg_we is high
// and must only be used while no item is in flight.
// Pipeline: an item accepted on in_ch is held in the input register; once
// the output register is free or being read, its state update and result are
// computed and registered in the output register, which drives out_ch.valid.
// Throughput is one item per cycle unless out_ch stalls; the channel and ramp
// state advance in a single pass of short logic between those two registers.
// When the receiver stalls, the result stays in the output register, the item
// behind it waits in the input register, and in_ch.ready drops only once both
// are full. Reset clears all channels and duties, sets the ramp rising from
// zero, and loads the register defaults.
module led_blink_breathe_controller
    import lbb_pkg::*;
#(
    parameter int LED_CHANNELS = LED_CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lbb_in_if.sink                in_ch,
    lbb_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [DUTY_W-1:0]        breathe_step_reg;
    logic [BREATHE_CNT_W-1:0] breathe_period_reg;
    logic [DUTY_W-1:0]        breathe_max_reg;
    logic [DUTY_W-1:0]        breathe_min_reg;
    logic [DUTY_W-1:0]        fault_duty_reg;

    // Input register stage.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_func_reg;
    logic [1:0]         s1_led_select_reg;
    logic [PULSE_W-1:0] s1_pulse_count_reg;
    logic [HALF_W-1:0]  s1_phase_len_reg;
    logic               s1_error_flag_reg;

    // Controller state.
    flash_state_t             chan_reg  [LED_CHANNELS];
    flash_state_t             chan_flash[LED_CHANNELS];
    flash_state_t             chan_next [LED_CHANNELS];
    logic [LED_CHANNELS-1:0]  chan_written;
    logic [BREATHE_CNT_W-1:0] breathe_cnt_reg;
    logic [BREATHE_CNT_W-1:0] breathe_cnt_next;
    logic [BREATHE_CNT_W-1:0] breathe_cnt_dec;
    logic [DUTY_W-1:0]        breathe_level_reg;
    logic [DUTY_W-1:0]        breathe_level_next;
    logic [DUTY_W-1:0]        ramp_level;
    logic                     breathe_rising_reg;
    logic                     breathe_rising_next;
    logic                     ramp_rising;

    // Result register stage.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DUTY_W-1:0]   out_duty_reg [OUT_LEDS];
    logic [OUT_LEDS-1:0] out_mask_reg;
    logic [OUT_LEDS-1:0] mask_next;

    logic in_fire;
    logic advance;
    logic s1_fire;
    logic is_tick;
    logic is_blink;
    logic ramp_step;

    // The input register may refill whenever its item moves on to the result register.
    assign advance     = ~out_valid_reg | out_ch.ready;
    assign in_ch.ready = ~s1_valid_reg | advance;
    assign in_fire     = in_ch.valid & in_ch.ready;
    assign s1_fire     = s1_valid_reg & advance;

    assign is_tick  = s1_fire & (func_t'(s1_func_reg) == FUNC_TICK);
    assign is_blink = s1_fire & (func_t'(s1_func_reg) == FUNC_BLINK);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Each channel decides its own blink step; the heartbeat and error
    // overrides are applied on top afterwards, in the same order as the
    // behaviour requires (ramp first, then the fault duty).
    for (genvar i = 0; i < LED_CHANNELS; i++)
    begin : g_chan
        flash_ctrl_t ctrl;

        assign ctrl = '{
            tick:        is_tick,
            load:        is_blink && (32'(s1_led_select_reg) == i),
            pulse_count: s1_pulse_count_reg,
            phase_len:   s1_phase_len_reg
        };

        lbb_flash_channel u_flash (
            .ctrl    (ctrl),
            .cur     (chan_reg[i]),
            .nxt     (chan_flash[i]),
            .written (chan_written[i])
        );
    end

    // The breathing countdown runs on every tick and sticks at zero.
    assign breathe_cnt_dec = (breathe_cnt_reg != '0) ? breathe_cnt_reg - 1'b1 : '0;

    // A ramp step needs an idle heartbeat channel and an expired countdown.
    assign ramp_step = is_tick && (chan_reg[HEARTBEAT_LED].pulses_left == '0)
                       && (breathe_cnt_dec == '0);

    lbb_breathe u_breathe (
        .level       (breathe_level_reg),
        .rising      (breathe_rising_reg),
        .step        (breathe_step_reg),
        .max_duty    (breathe_max_reg),
        .min_duty    (breathe_min_reg),
        .level_next  (ramp_level),
        .rising_next (ramp_rising)
    );

    always_comb
    begin
        breathe_cnt_next    = breathe_cnt_reg;
        breathe_level_next  = breathe_level_reg;
        breathe_rising_next = breathe_rising_reg;
        if (ramp_step)
        begin
            breathe_cnt_next    = breathe_period_reg;
            breathe_level_next  = ramp_level;
            breathe_rising_next = ramp_rising;
        end
        else if (is_tick)
        begin
            breathe_cnt_next = breathe_cnt_dec;
        end
    end

    always_comb
    begin
        for (int i = 0; i < LED_CHANNELS; i++)
        begin
            chan_next[i] = chan_flash[i];
        end
        mask_next = chan_written[OUT_LEDS-1:0];
        if (ramp_step)
        begin
            chan_next[HEARTBEAT_LED].duty = ramp_level;
            mask_next[HEARTBEAT_LED]      = 1'b1;
        end
        if (is_tick && s1_error_flag_reg)
        begin
            chan_next[ERROR_LED].duty = fault_duty_reg;
            mask_next[ERROR_LED]      = 1'b1;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            breathe_step_reg   <= BREATHE_STEP_RST;
            breathe_period_reg <= BREATHE_PERIOD_RST;
            breathe_max_reg    <= BREATHE_MAX_RST;
            breathe_min_reg    <= BREATHE_MIN_RST;
            fault_duty_reg     <= FAULT_DUTY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_BREATHE_STEP:      breathe_step_reg   <= cfg_wdata;
                CFG_BREATHE_PERIOD_MS: breathe_period_reg <= cfg_wdata[BREATHE_CNT_W-1:0];
                CFG_BREATHE_MAX_DUTY:  breathe_max_reg    <= cfg_wdata;
                CFG_BREATHE_MIN_DUTY:  breathe_min_reg    <= cfg_wdata;
                CFG_FAULT_DUTY:        fault_duty_reg     <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    // Handshake control and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            breathe_cnt_reg    <= '0;
            breathe_level_reg  <= '0;
            breathe_rising_reg <= 1'b1;
            for (int i = 0; i < LED_CHANNELS; i++)
            begin
                chan_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                breathe_cnt_reg    <= breathe_cnt_next;
                breathe_level_reg  <= breathe_level_next;
                breathe_rising_reg <= breathe_rising_next;
                for (int i = 0; i < LED_CHANNELS; i++)
                begin
                    chan_reg[i] <= chan_next[i];
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg        <= in_ch.func;
            s1_led_select_reg  <= in_ch.led_select;
            s1_pulse_count_reg <= in_ch.pulse_count;
            s1_phase_len_reg   <= in_ch.pulse_length_ms[LEN_W-1:1];
            s1_error_flag_reg  <= in_ch.error_flag;
        end
        if (s1_fire)
        begin
            for (int i = 0; i < OUT_LEDS; i++)
            begin
                out_duty_reg[i] <= chan_next[i].duty;
            end
            out_mask_reg <= mask_next;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.error_led_duty     = out_duty_reg[ERROR_LED];
    assign out_ch.heartbeat_led_duty = out_duty_reg[HEARTBEAT_LED];
    assign out_ch.indicator_led_duty = out_duty_reg[INDICATOR_LED];
    assign out_ch.written_mask       = out_mask_reg;

endmodule
